/* src/anchor_box_offset_decoder_top_defines.svh */
// Assertion macros for the anchor box offset decoder.
// Included by the decoder top level, which checks its own pipeline behavior.
`ifndef ANCHOR_BOX_OFFSET_DECODER_TOP_DEFINES_SVH
`define ANCHOR_BOX_OFFSET_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication check.
`define ABOD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("abod: same-cycle check failed");

// Next-cycle implication check.
`define ABOD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("abod: next-cycle check failed");

`else

`define ABOD_ASSERT_IMPL(label, clk, rst, ante, cons)

`define ABOD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* src/abod_pkg.sv */
// Shared types, register codes and arithmetic constants of the anchor box offset decoder.
// Used by the channel interfaces and the decoder top level; depends on nothing.
package abod_pkg;

   typedef logic        [15:0] prior_type;
   typedef logic signed [15:0] offset_type;
   typedef logic signed [15:0] box_type;

   // Pipeline depth from input register to output register.
   localparam int STAGES = 20;

   // Register map: register index sits at paddr[3:2].
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_CENTER_VAR = 2'd0;
   localparam logic [1:0] REG_SIZE_VAR   = 2'd1;
   localparam logic [1:0] REG_IMAGE_W    = 2'd2;
   localparam logic [1:0] REG_IMAGE_H    = 2'd3;

   localparam logic [15:0] CENTER_VAR_RESET = 16'd6554;
   localparam logic [15:0] SIZE_VAR_RESET   = 16'd13107;
   localparam logic [12:0] IMAGE_W_RESET    = 13'd1024;
   localparam logic [12:0] IMAGE_H_RESET    = 13'd1024;

   // Exponent argument limits in Q.28: -8 and +4.
   localparam logic signed [32:0] EXP_LO     = 33'sh1_8000_0000;
   localparam logic signed [32:0] EXP_HI     = 33'sh0_4000_0000;
   localparam logic        [31:0] EXP_LO_MAG = 32'h8000_0000;
   localparam logic        [31:0] EXP_HI_MAG = 32'h4000_0000;

   localparam logic [63:0] HALF_Q36 = 64'h8_0000_0000;
   localparam logic [63:0] HALF_Q28 = 64'h800_0000;
   localparam logic [37:0] ONE_Q36  = 38'h10_0000_0000;
   localparam logic [37:0] HALF_Q8  = 38'd128;
   localparam logic [52:0] HALF_Q16 = 53'h8000;

   // Pixel scaling divides by 5 * 2^22 with rounding; saturation threshold in quotient units.
   localparam logic [50:0] PIX_HALF = 51'd10485760;
   localparam logic [28:0] PIX_SAT  = 29'd163840;
   localparam box_type BOX_MAX = 16'sh7FFF;
   localparam box_type BOX_MIN = 16'sh8000;

   // Reciprocal multipliers, exact over the stated input widths.
   localparam logic [21:0] DIV3_MUL = 22'd2796203;
   localparam logic [18:0] DIV5_MUL = 19'd419431;

   // floor(x / 3) for x below 2^21.
   function automatic logic [19:0] div3_q(input logic [20:0] x);
      logic [42:0] prod;
      prod = 43'(x) * 43'(DIV3_MUL);
      return prod[42:23];
   endfunction

   // floor(x / 5) for x below 2^18.
   function automatic logic [15:0] div5_q(input logic [17:0] x);
      logic [36:0] prod;
      prod = 37'(x) * 37'(DIV5_MUL);
      return prod[36:21];
   endfunction

endpackage

/* src/abod_if.sv */
// Valid/ready channel interfaces for the anchor box offset decoder.
// Depends on abod_pkg for the payload types.
interface abod_req_if;
   logic                   valid;
   logic                   ready;
   abod_pkg::prior_type    prior_cx;
   abod_pkg::prior_type    prior_cy;
   abod_pkg::prior_type    prior_w;
   abod_pkg::prior_type    prior_h;
   abod_pkg::offset_type   off_x;
   abod_pkg::offset_type   off_y;
   abod_pkg::offset_type   off_w;
   abod_pkg::offset_type   off_h;

   modport source (output valid, prior_cx, prior_cy, prior_w, prior_h,
                   off_x, off_y, off_w, off_h, input ready);
   modport sink   (input valid, prior_cx, prior_cy, prior_w, prior_h,
                   off_x, off_y, off_w, off_h, output ready);
endinterface

interface abod_rsp_if;
   logic                valid;
   logic                ready;
   abod_pkg::box_type   box_x1;
   abod_pkg::box_type   box_y1;
   abod_pkg::box_type   box_x2;
   abod_pkg::box_type   box_y2;

   modport source (output valid, box_x1, box_y1, box_x2, box_y2, input ready);
   modport sink   (input valid, box_x1, box_y1, box_x2, box_y2, output ready);
endinterface

/* src/anchor_box_offset_decoder_top.sv */
// Anchor box offset decoder: a fully pipelined SSD-style box decode with an APB register port.
// Depends on abod_pkg, the channel interfaces in abod_if.sv and the assertion macro header.
//
// Usage:
//   req_chan carries one word per anchor: prior center and size (unsigned Q2.14) and four
//   regressed offsets (signed Q4.12). rsp_chan returns one word per anchor: the four box
//   corners in signed Q12.4 pixels, saturated. A word moves when valid and ready are high.
//   The csr_ APB port holds center and size variance (Q0.16) and the image width and height;
//   write it only while no word is in flight.
//   An accepted word passes every stage register before rsp_chan.valid; a new word can
//   enter every cycle unless rsp_chan stalls with every stage full. Depth is set by the
//   exponent path: a quartic series, a rescale and eight chained squarings, each registered.
//   Each stage has its own valid bit; a stalled rsp_chan holds the output word, and bubbles
//   further back still fill, so req_chan.ready drops only when every stage holds a word.
//   Reset (synchronous, active high) empties the pipeline and loads the register defaults:
//   variances 0.1 and 0.2, image size 1024 by 1024.
`include "anchor_box_offset_decoder_top_defines.svh"

module anchor_box_offset_decoder_top (
   input  logic                              clock,
   input  logic                              reset,
   abod_req_if.sink                          req_chan,
   abod_rsp_if.source                        rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [abod_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   // ---------------------------------------------------------------- registers
   logic [15:0] center_var_ff, center_var_in;
   logic [15:0] size_var_ff, size_var_in;
   logic [12:0] image_w_ff, image_w_in;
   logic [12:0] image_h_ff, image_h_in;
   logic        csr_write;

   // ---------------------------------------------------------------- control
   logic [abod_pkg::STAGES:1] vld_ff, vld_in;
   logic [abod_pkg::STAGES:1] en;

   // ---------------------------------------------------------------- per-axis datapath
   abod_pkg::offset_type off_c [2];
   abod_pkg::offset_type off_l [2];
   logic signed [32:0]   arg1 [2];

   logic [15:0]        c1_ff [2], c1_in [2];
   logic signed [32:0] pd1_ff [2], pd1_in [2];
   logic [15:0]        s_ff [1:14][2], s_in [1:14][2];
   logic [31:0]        a_ff [1:5][2], a_in [1:5][2];
   logic               neg_ff [1:5][2], neg_in [1:5][2];

   logic signed [48:0] shift2 [2];
   logic [63:0]        sq2 [2];
   logic signed [48:0] c42_ff [2:15][2], c42_in [2:15][2];
   logic [26:0]        a2_ff [2:5][2], a2_in [2:5][2];

   logic [58:0]        p3 [2];
   logic [21:0]        a3_ff [2], a3_in [2];

   logic [53:0]        p4 [2];
   logic [16:0]        a4_ff [2], a4_in [2];
   logic [19:0]        a3d6_ff [4:5][2], a3d6_in [4:5][2];

   logic [11:0]        a4d24_ff [2], a4d24_in [2];

   logic [37:0]        e6 [2];
   logic [37:0]        e6r [2];
   logic [63:0]        psq [1:8][2];
   logic [33:0]        sq_ff [0:8][2], sq_in [0:8][2];

   logic [49:0]        w42_ff [2], w42_in [2];
   logic signed [52:0] c2x [2];
   logic signed [52:0] w2x [2];

   // ---------------------------------------------------------------- per-corner datapath
   // Corner order: x1, y1, x2, y2. Bit 0 picks the axis, bit 1 the far edge.
   logic signed [52:0]   tw_ff [4], tw_in [4];
   logic [52:0]          abs17 [4];
   logic [52:0]          rnd17 [4];
   logic [36:0]          mag_ff [4], mag_in [4];
   logic                 cneg_ff [17:19][4], cneg_in [17:19][4];
   logic [49:0]          prod_ff [4], prod_in [4];
   logic [50:0]          rnd19 [4];
   logic [17:0]          t_ff [4], t_in [4];
   logic                 sat_ff [4], sat_in [4];
   logic [15:0]          q20 [4];
   abod_pkg::box_type    box_ff [4], box_in [4];

   // ================================================================ register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      center_var_in = center_var_ff;
      size_var_in   = size_var_ff;
      image_w_in    = image_w_ff;
      image_h_in    = image_h_ff;
      if (csr_write) begin
         case (csr_paddr[abod_pkg::CSR_ADDR_W-1:2])
            abod_pkg::REG_CENTER_VAR: center_var_in = csr_pwdata[15:0];
            abod_pkg::REG_SIZE_VAR:   size_var_in   = csr_pwdata[15:0];
            abod_pkg::REG_IMAGE_W:    image_w_in    = csr_pwdata[12:0];
            abod_pkg::REG_IMAGE_H:    image_h_in    = csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[abod_pkg::CSR_ADDR_W-1:2])
         abod_pkg::REG_CENTER_VAR: csr_prdata = {16'b0, center_var_ff};
         abod_pkg::REG_SIZE_VAR:   csr_prdata = {16'b0, size_var_ff};
         abod_pkg::REG_IMAGE_W:    csr_prdata = {19'b0, image_w_ff};
         abod_pkg::REG_IMAGE_H:    csr_prdata = {19'b0, image_h_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_var_ff <= abod_pkg::CENTER_VAR_RESET;
         size_var_ff   <= abod_pkg::SIZE_VAR_RESET;
         image_w_ff    <= abod_pkg::IMAGE_W_RESET;
         image_h_ff    <= abod_pkg::IMAGE_H_RESET;
      end else begin
         center_var_ff <= center_var_in;
         size_var_ff   <= size_var_in;
         image_w_ff    <= image_w_in;
         image_h_ff    <= image_h_in;
      end
   end

   // ================================================================ pipeline control
   // A stage loads when it is empty or its word moves on, so bubbles close up under a stall.
   always_comb begin
      en[abod_pkg::STAGES] = !vld_ff[abod_pkg::STAGES] || rsp_chan.ready;
      for (int i = abod_pkg::STAGES - 1; i >= 1; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   always_comb begin
      vld_in[1] = req_chan.valid;
      for (int i = 2; i <= abod_pkg::STAGES; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 1; i <= abod_pkg::STAGES; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_chan.ready = en[1];
   assign rsp_chan.valid = vld_ff[abod_pkg::STAGES];
   assign rsp_chan.box_x1 = box_ff[0];
   assign rsp_chan.box_y1 = box_ff[1];
   assign rsp_chan.box_x2 = box_ff[2];
   assign rsp_chan.box_y2 = box_ff[3];

   // ================================================================ stage 1
   // Offset times center variance, and the clamped exponent argument split into sign
   // and magnitude.
   assign c1_in[0] = req_chan.prior_cx;
   assign c1_in[1] = req_chan.prior_cy;
   assign off_c[0] = req_chan.off_x;
   assign off_c[1] = req_chan.off_y;
   assign off_l[0] = req_chan.off_w;
   assign off_l[1] = req_chan.off_h;

   always_comb begin
      for (int ax = 0; ax < 2; ax++) begin
         pd1_in[ax] = 33'(off_c[ax]) * 33'($signed({1'b0, center_var_ff}));
         arg1[ax]   = 33'(off_l[ax]) * 33'($signed({1'b0, size_var_ff}));
         if (arg1[ax] < abod_pkg::EXP_LO) begin
            a_in[1][ax]   = abod_pkg::EXP_LO_MAG;
            neg_in[1][ax] = 1'b1;
         end else if (arg1[ax] > abod_pkg::EXP_HI) begin
            a_in[1][ax]   = abod_pkg::EXP_HI_MAG;
            neg_in[1][ax] = 1'b0;
         end else if (arg1[ax][32]) begin
            a_in[1][ax]   = 32'(-arg1[ax]);
            neg_in[1][ax] = 1'b1;
         end else begin
            a_in[1][ax]   = arg1[ax][31:0];
            neg_in[1][ax] = 1'b0;
         end
         for (int i = 2; i <= 5; i++) begin
            a_in[i][ax]   = a_ff[i-1][ax];
            neg_in[i][ax] = neg_ff[i-1][ax];
         end
      end
   end

   always_comb begin
      s_in[1][0] = req_chan.prior_w;
      s_in[1][1] = req_chan.prior_h;
      for (int i = 2; i <= 14; i++) begin
         s_in[i] = s_ff[i-1];
      end
   end

   // ================================================================ stages 2 to 5
   // The series argument a is read as a/256 in Q.36, so these are its powers in Q.36.
   always_comb begin
      for (int ax = 0; ax < 2; ax++) begin
         shift2[ax] = 49'(pd1_ff[ax]) * 49'($signed({1'b0, s_ff[1][ax]}));
         c42_in[2][ax] = $signed({5'b0, c1_ff[ax], 28'b0}) + shift2[ax];
         sq2[ax] = 64'(a_ff[1][ax]) * 64'(a_ff[1][ax]) + abod_pkg::HALF_Q36;
         a2_in[2][ax] = sq2[ax][62:36];

         p3[ax] = 59'(a2_ff[2][ax]) * 59'(a_ff[2][ax]) + 59'(abod_pkg::HALF_Q36);
         a3_in[ax] = p3[ax][57:36];

         p4[ax] = 54'(a3_ff[ax]) * 54'(a_ff[3][ax]) + 54'(abod_pkg::HALF_Q36);
         a4_in[ax] = p4[ax][52:36];
         a3d6_in[4][ax] = abod_pkg::div3_q(a3_ff[ax][21:1]);

         a3d6_in[5][ax] = a3d6_ff[4][ax];
         a4d24_in[ax] = 12'(abod_pkg::div3_q(21'(a4_ff[ax][16:3])));

         for (int i = 3; i <= 5; i++) begin
            a2_in[i][ax] = a2_ff[i-1][ax];
         end
      end
   end

   always_comb begin
      for (int i = 3; i <= 15; i++) begin
         c42_in[i] = c42_ff[i-1];
      end
   end

   // ================================================================ stage 6
   // Series sum for exp(a/256), then rescale from Q.36 to Q.28.
   always_comb begin
      for (int ax = 0; ax < 2; ax++) begin
         if (neg_ff[5][ax]) begin
            e6[ax] = abod_pkg::ONE_Q36 + 38'(a2_ff[5][ax][26:1]) + 38'(a4d24_ff[ax])
                     - 38'(a_ff[5][ax]) - 38'(a3d6_ff[5][ax]);
         end else begin
            e6[ax] = abod_pkg::ONE_Q36 + 38'(a_ff[5][ax]) + 38'(a2_ff[5][ax][26:1])
                     + 38'(a3d6_ff[5][ax]) + 38'(a4d24_ff[ax]);
         end
         e6r[ax] = e6[ax] + abod_pkg::HALF_Q8;
         sq_in[0][ax] = 34'(e6r[ax][37:8]);
      end
   end

   // ================================================================ stages 7 to 14
   // Eight squarings raise the value to the 256th power. Every squaring input stays
   // below e^2 in Q.28, so 32 bits of it are enough.
   always_comb begin
      for (int k = 1; k <= 8; k++) begin
         for (int ax = 0; ax < 2; ax++) begin
            psq[k][ax] = 64'(sq_ff[k-1][ax][31:0]) * 64'(sq_ff[k-1][ax][31:0])
                         + abod_pkg::HALF_Q28;
            sq_in[k][ax] = psq[k][ax][61:28];
         end
      end
   end

   // ================================================================ stages 15 and 16
   // New size in Q.42, then the doubled corners 2*c - w and 2*c + w.
   always_comb begin
      for (int ax = 0; ax < 2; ax++) begin
         w42_in[ax] = 50'(sq_ff[8][ax]) * 50'(s_ff[14][ax]);
         c2x[ax] = 53'(c42_ff[15][ax]) <<< 1;
         w2x[ax] = $signed({3'b0, w42_ff[ax]});
      end
      for (int k = 0; k < 4; k++) begin
         if (k >= 2) begin
            tw_in[k] = c2x[k % 2] + w2x[k % 2];
         end else begin
            tw_in[k] = c2x[k % 2] - w2x[k % 2];
         end
      end
   end

   // ================================================================ stages 17 to 20
   // Sign and magnitude from here on; both roundings go half away from zero.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         abs17[k] = tw_ff[k][52] ? 53'(-tw_ff[k]) : 53'(tw_ff[k]);
         rnd17[k] = abs17[k] + abod_pkg::HALF_Q16;
         mag_in[k] = rnd17[k][52:16];
         cneg_in[17][k] = tw_ff[k][52];

         prod_in[k] = 50'(mag_ff[k]) * 50'((k % 2 == 1) ? image_h_ff : image_w_ff);
         cneg_in[18][k] = cneg_ff[17][k];

         rnd19[k] = 51'(prod_ff[k]) + abod_pkg::PIX_HALF;
         sat_in[k] = rnd19[k][50:22] >= abod_pkg::PIX_SAT;
         t_in[k] = rnd19[k][39:22];
         cneg_in[19][k] = cneg_ff[18][k];

         q20[k] = abod_pkg::div5_q(t_ff[k]);
         if (sat_ff[k]) begin
            box_in[k] = cneg_ff[19][k] ? abod_pkg::BOX_MIN : abod_pkg::BOX_MAX;
         end else if (cneg_ff[19][k]) begin
            box_in[k] = -$signed(q20[k]);
         end else begin
            box_in[k] = $signed(q20[k]);
         end
      end
   end

   // ================================================================ payload registers
   always_ff @(posedge clock) begin
      if (en[1]) begin
         c1_ff  <= c1_in;
         pd1_ff <= pd1_in;
      end
      for (int i = 1; i <= 14; i++) begin
         if (en[i]) begin
            s_ff[i] <= s_in[i];
         end
      end
      for (int i = 1; i <= 5; i++) begin
         if (en[i]) begin
            a_ff[i]   <= a_in[i];
            neg_ff[i] <= neg_in[i];
         end
      end
      for (int i = 2; i <= 15; i++) begin
         if (en[i]) begin
            c42_ff[i] <= c42_in[i];
         end
      end
      for (int i = 2; i <= 5; i++) begin
         if (en[i]) begin
            a2_ff[i] <= a2_in[i];
         end
      end
      if (en[3]) begin
         a3_ff <= a3_in;
      end
      if (en[4]) begin
         a4_ff      <= a4_in;
         a3d6_ff[4] <= a3d6_in[4];
      end
      if (en[5]) begin
         a3d6_ff[5] <= a3d6_in[5];
         a4d24_ff   <= a4d24_in;
      end
      for (int k = 0; k <= 8; k++) begin
         if (en[6+k]) begin
            sq_ff[k] <= sq_in[k];
         end
      end
      if (en[15]) begin
         w42_ff <= w42_in;
      end
      if (en[16]) begin
         tw_ff <= tw_in;
      end
      if (en[17]) begin
         mag_ff      <= mag_in;
         cneg_ff[17] <= cneg_in[17];
      end
      if (en[18]) begin
         prod_ff     <= prod_in;
         cneg_ff[18] <= cneg_in[18];
      end
      if (en[19]) begin
         t_ff        <= t_in;
         sat_ff      <= sat_in;
         cneg_ff[19] <= cneg_in[19];
      end
      if (en[20]) begin
         box_ff <= box_in;
      end
   end

   // ================================================================ checks
   `ABOD_ASSERT_NEXT(a_accept_fills_first, clock, reset, req_chan.valid && req_chan.ready, vld_ff[1])
   `ABOD_ASSERT_IMPL(a_ready_low_only_full, clock, reset, !req_chan.ready, vld_ff[1] && rsp_chan.valid && !rsp_chan.ready)
   `ABOD_ASSERT_NEXT(a_mid_stage_holds, clock, reset, vld_ff[10] && !en[10], vld_ff[10])
   `ABOD_ASSERT_IMPL(a_last_square_in_range, clock, reset, vld_ff[13], sq_ff[7][0][33:32] == 2'b00 && sq_ff[7][1][33:32] == 2'b00)
   `ABOD_ASSERT_IMPL(a_exp_nonzero, clock, reset, vld_ff[14], sq_ff[8][0] != 34'd0 && sq_ff[8][1] != 34'd0)

endmodule

/* test/tb_anchor_box_offset_decoder_top.sv */
// Self-checking testbench for anchor_box_offset_decoder_top: directed anchors, then random ones.
// Depends on abod_pkg, the channel interfaces in abod_if.sv and the decoder RTL.
module tb_anchor_box_offset_decoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   import abod_pkg::*;

   typedef struct {
      prior_type  cx;
      prior_type  cy;
      prior_type  w;
      prior_type  h;
      offset_type ox;
      offset_type oy;
      offset_type ow;
      offset_type oh;
   } anchor_word;

   typedef struct {
      box_type x1;
      box_type y1;
      box_type x2;
      box_type y2;
   } box_word;

   typedef struct {
      logic [15:0] center_var;
      logic [15:0] size_var;
      logic [12:0] image_w;
      logic [12:0] image_h;
   } decode_settings;

   typedef struct {
      int         set_sel;
      anchor_word anchor;
      bit         fixed;
      box_word    box;
   } stim_row;

   localparam int SET_RESET = 0;
   localparam int SET_WIDE  = 1;
   localparam int SET_ZERO  = 2;
   localparam int SET_ODD   = 3;
   localparam int SET_MIXED = 4;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 240;
   localparam int TAIL_ITEMS    = 200;
   localparam int HOLD_ITEMS    = 60;
   localparam int HOLD_CYCLES   = 80;

   localparam longint unsigned Q36_UNIT   = 64'd1 << 36;
   localparam longint unsigned Q36_ROUND  = 64'd1 << 35;
   localparam longint unsigned Q28_ROUND  = 64'd1 << 27;
   localparam longint          ARG_FLOOR  = -(longint'(8) << 28);
   localparam longint          ARG_CEIL   = longint'(4) << 28;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   abod_req_if req_bus ();
   abod_rsp_if rsp_bus ();

   anchor_box_offset_decoder_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Register copies used by the box predictor.
   logic [15:0] pred_center_var = CENTER_VAR_RESET;
   logic [15:0] pred_size_var   = SIZE_VAR_RESET;
   logic [12:0] pred_image_w    = IMAGE_W_RESET;
   logic [12:0] pred_image_h    = IMAGE_H_RESET;

   box_word        pending_boxes[$];
   stim_row        directed_rows[$];
   decode_settings settings_table[5];
   int  mismatch_count = 0;
   int  cycle_count = 0;
   bit  req_gaps_on = 1'b0;
   bit  rsp_idle_on = 1'b0;
   int  rsp_hold_cycles = 0;

   always #5 clock = ~clock;

   // n / d to nearest, halves away from zero.
   function automatic longint div_round_away(input longint n, input longint unsigned d);
      longint unsigned mag;
      longint unsigned q;
      mag = (n < 0) ? -n : n;
      q = (mag + d / 2) / d;
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   // e^arg for a Q.28 argument in [-8, 4]: series on arg/256, then eight squarings.
   function automatic longint unsigned pow_e_q28(input longint arg);
      longint unsigned a;
      longint unsigned a2;
      longint unsigned a3;
      longint unsigned a4;
      longint unsigned e;
      longint unsigned s;
      a  = (arg < 0) ? -arg : arg;
      a2 = (a * a + Q36_ROUND) >> 36;
      a3 = (a2 * a + Q36_ROUND) >> 36;
      a4 = (a3 * a + Q36_ROUND) >> 36;
      if (arg >= 0) begin
         e = Q36_UNIT + a + a2 / 2 + a3 / 6 + a4 / 24;
      end else begin
         e = Q36_UNIT + a2 / 2 + a4 / 24 - a - a3 / 6;
      end
      s = (e + 64'd128) >> 8;
      for (int i = 0; i < 8; i++) begin
         s = (s * s + Q28_ROUND) >> 28;
      end
      return s;
   endfunction

   // Doubled low and high edges of one axis, in Q.42.
   function automatic void edge_pair(input prior_type c, input prior_type s,
                                     input offset_type doff, input offset_type soff,
                                     output longint lo2, output longint hi2);
      longint c42;
      longint arg;
      longint w42;
      c42 = (longint'(c) << 28) + longint'(doff) * longint'(pred_center_var) * longint'(s);
      arg = longint'(soff) * longint'(pred_size_var);
      if (arg < ARG_FLOOR) arg = ARG_FLOOR;
      if (arg > ARG_CEIL) arg = ARG_CEIL;
      w42 = longint'(s) * longint'(pow_e_q28(arg));
      lo2 = 2 * c42 - w42;
      hi2 = lo2 + 2 * w42;
   endfunction

   function automatic box_type scale_corner(input longint twice_q42, input logic [12:0] size);
      longint v26;
      longint r;
      v26 = div_round_away(twice_q42, 64'd1 << 16);
      r = div_round_away(v26 * longint'(size), 64'd5 << 22);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic box_word decode_anchor(input anchor_word a);
      longint  x_lo;
      longint  x_hi;
      longint  y_lo;
      longint  y_hi;
      box_word b;
      edge_pair(a.cx, a.w, a.ox, a.ow, x_lo, x_hi);
      edge_pair(a.cy, a.h, a.oy, a.oh, y_lo, y_hi);
      b.x1 = scale_corner(x_lo, pred_image_w);
      b.y1 = scale_corner(y_lo, pred_image_h);
      b.x2 = scale_corner(x_hi, pred_image_w);
      b.y2 = scale_corner(y_hi, pred_image_h);
      return b;
   endfunction

   function automatic logic [15:0] boundary_value();
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly plausible anchors (inside the image, offsets within +-1.0), the rest raw noise or boundary values.
   function automatic anchor_word random_anchor();
      anchor_word a;
      int         kind;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         a.cx = $urandom_range(0, 16384);
         a.cy = $urandom_range(0, 16384);
         a.w  = $urandom_range(64, 16384);
         a.h  = $urandom_range(64, 16384);
         a.ox = offset_type'(int'($urandom_range(0, 8191)) - 4096);
         a.oy = offset_type'(int'($urandom_range(0, 8191)) - 4096);
         a.ow = offset_type'(int'($urandom_range(0, 8191)) - 4096);
         a.oh = offset_type'(int'($urandom_range(0, 8191)) - 4096);
      end else if (kind < 9) begin
         a.cx = 16'($urandom);
         a.cy = 16'($urandom);
         a.w  = 16'($urandom);
         a.h  = 16'($urandom);
         a.ox = 16'($urandom);
         a.oy = 16'($urandom);
         a.ow = 16'($urandom);
         a.oh = 16'($urandom);
      end else begin
         a.cx = boundary_value();
         a.cy = boundary_value();
         a.w  = boundary_value();
         a.h  = boundary_value();
         a.ox = boundary_value();
         a.oy = boundary_value();
         a.ow = boundary_value();
         a.oh = boundary_value();
      end
      return a;
   endfunction

   function automatic decode_settings random_settings();
      decode_settings s;
      s.center_var = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(3000, 14000);
      s.size_var   = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(6000, 20000);
      for (int axis = 0; axis < 2; axis++) begin
         logic [12:0] size;
         case ($urandom_range(0, 7))
            0: size = 13'd0;
            1: size = $urandom_range(4097, 8191);
            default: size = $urandom_range(1, 4096);
         endcase
         if (axis == 0) s.image_w = size;
         else s.image_h = size;
      end
      return s;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input box_type got, input box_type want);
      if (got !== want) begin
         flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
      end
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      case (index)
         REG_CENTER_VAR: pred_center_var = value[15:0];
         REG_SIZE_VAR:   pred_size_var   = value[15:0];
         REG_IMAGE_W:    pred_image_w    = value[12:0];
         REG_IMAGE_H:    pred_image_h    = value[12:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input decode_settings s);
      csr_write(REG_CENTER_VAR, 32'(s.center_var));
      csr_write(REG_SIZE_VAR, 32'(s.size_var));
      csr_write(REG_IMAGE_W, 32'(s.image_w));
      csr_write(REG_IMAGE_H, 32'(s.image_h));
   endtask

   // Wait for every outstanding box, then let the pipeline settle.
   task automatic drain_boxes();
      while (pending_boxes.size() != 0) @(posedge clock);
      repeat (STAGES + 10) @(posedge clock);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic offer_anchor(input anchor_word a, input bit fixed, input box_word box);
      @(negedge clock);
      if (req_gaps_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_bus.prior_cx = a.cx;
      req_bus.prior_cy = a.cy;
      req_bus.prior_w  = a.w;
      req_bus.prior_h  = a.h;
      req_bus.off_x    = a.ox;
      req_bus.off_y    = a.oy;
      req_bus.off_w    = a.ow;
      req_bus.off_h    = a.oh;
      req_bus.valid    = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      pending_boxes.push_back(fixed ? box : decode_anchor(a));
   endtask

   task automatic add_row(input int sel, input logic [15:0] cx, input logic [15:0] cy,
                          input logic [15:0] w, input logic [15:0] h,
                          input logic [15:0] ox, input logic [15:0] oy,
                          input logic [15:0] ow, input logic [15:0] oh,
                          input bit fixed, input box_word box);
      stim_row r;
      r.set_sel = sel;
      r.anchor  = '{cx, cy, w, h, ox, oy, ow, oh};
      r.fixed   = fixed;
      r.box     = box;
      directed_rows.push_back(r);
   endtask

   // Result side: random stall bursts, plus a long hold-off when one is requested.
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            rsp_hold_cycles--;
         end else if (!rsp_idle_on) begin
            rsp_bus.ready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_bus.ready = 1'b0;
            stall_left = $urandom_range(0, 7);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      box_word want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_boxes.size() == 0) begin
            flag_mismatch("box word with none outstanding");
         end else begin
            want = pending_boxes.pop_front();
            check_field("box_x1", rsp_bus.box_x1, want.x1);
            check_field("box_y1", rsp_bus.box_y1, want.y1);
            check_field("box_x2", rsp_bus.box_x2, want.x2);
            check_field("box_y2", rsp_bus.box_y2, want.y2);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_anchor_box_offset_decoder_top NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      box_word zeros;
      box_word clipped;
      box_word half_way;
      int      active_set;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.prior_cx = '0;
      req_bus.prior_cy = '0;
      req_bus.prior_w = '0;
      req_bus.prior_h = '0;
      req_bus.off_x = '0;
      req_bus.off_y = '0;
      req_bus.off_w = '0;
      req_bus.off_h = '0;

      settings_table[SET_RESET] = '{CENTER_VAR_RESET, SIZE_VAR_RESET, IMAGE_W_RESET, IMAGE_H_RESET};
      settings_table[SET_WIDE]  = '{16'd65535, 16'd65535, 13'd4096, 13'd4096};
      settings_table[SET_ZERO]  = '{16'd0, 16'd0, 13'd0, 13'd0};
      settings_table[SET_ODD]   = '{16'd1, 16'd1, 13'd8191, 13'd1};
      settings_table[SET_MIXED] = '{16'd6554, 16'd13107, 13'd8191, 13'd0};

      zeros    = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
      clipped  = '{BOX_MIN, BOX_MIN, BOX_MAX, BOX_MAX};
      // A zero-size anchor at the far corner lands at 4.0 * 1024 / 2.5 pixels.
      half_way = '{16'sd26214, 16'sd26214, 16'sd26214, 16'sd26214};

      add_row(SET_RESET, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
              16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, zeros);
      add_row(SET_RESET, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
              16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, half_way);
      add_row(SET_RESET, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 1'b1, clipped);
      add_row(SET_RESET, 16'h4000, 16'h4000, 16'h1000, 16'h1000,
              16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, zeros);
      add_row(SET_RESET, 16'h2000, 16'h6000, 16'h0800, 16'h3000,
              16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 1'b0, zeros);
      add_row(SET_RESET, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
              16'h1000, 16'hF000, 16'h7FFF, 16'h8000, 1'b0, zeros);
      add_row(SET_RESET, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
              16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b0, zeros);
      add_row(SET_RESET, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
              16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 1'b0, zeros);
      add_row(SET_RESET, 16'h4000, 16'h4000, 16'h2000, 16'h2000,
              16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 1'b0, zeros);
      add_row(SET_WIDE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
              16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, zeros);
      add_row(SET_WIDE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 1'b1, clipped);
      add_row(SET_WIDE, 16'h8000, 16'h8000, 16'h4000, 16'h4000,
              16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0, zeros);
      add_row(SET_WIDE, 16'h1234, 16'h4321, 16'h0100, 16'h0200,
              16'h0800, 16'hF800, 16'h1000, 16'hF000, 1'b0, zeros);
      add_row(SET_ZERO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, zeros);
      add_row(SET_ZERO, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
              16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, zeros);
      add_row(SET_ODD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 1'b0, zeros);
      add_row(SET_ODD, 16'h4000, 16'h4000, 16'h1000, 16'h1000,
              16'h1000, 16'h1000, 16'h1000, 16'h1000, 1'b0, zeros);
      add_row(SET_MIXED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 1'b0, zeros);
      add_row(SET_MIXED, 16'h3000, 16'h3000, 16'h0400, 16'h0400,
              16'hFC00, 16'h0400, 16'h0200, 16'hFE00, 1'b0, zeros);
      add_row(SET_RESET, 16'h2000, 16'h2000, 16'h1000, 16'h1000,
              16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, zeros);

      repeat (9) @(negedge clock);
      reset = 1'b0;

      active_set = SET_RESET;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_sel != active_set) begin
            release_req();
            drain_boxes();
            active_set = directed_rows[i].set_sel;
            apply_settings(settings_table[active_set]);
         end
         offer_anchor(directed_rows[i].anchor, directed_rows[i].fixed, directed_rows[i].box);
      end
      release_req();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_boxes();
         apply_settings(phase == 0 ? settings_table[SET_RESET] : random_settings());
         req_gaps_on = (phase % 3) != 1;
         rsp_idle_on = (phase % 3) != 2;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (phase == 2 && k == 100) begin
               // Hold the result side long enough for every stage to fill.
               req_gaps_on = 1'b0;
               rsp_hold_cycles = HOLD_CYCLES;
               repeat (HOLD_ITEMS) offer_anchor(random_anchor(), 1'b0, zeros);
               req_gaps_on = 1'b1;
            end
            if (phase == 4 && k == 120) begin
               release_req();
               drain_boxes();
            end
            offer_anchor(random_anchor(), 1'b0, zeros);
         end
         release_req();
      end

      drain_boxes();
      apply_settings(settings_table[SET_RESET]);
      req_gaps_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (TAIL_ITEMS) offer_anchor(random_anchor(), 1'b0, zeros);
      release_req();
      drain_boxes();

      if (mismatch_count == 0) begin
         $display("tb_anchor_box_offset_decoder_top OK");
      end else begin
         $display("tb_anchor_box_offset_decoder_top NOT OK");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/abod_pkg.sv
src/abod_if.sv
src/anchor_box_offset_decoder_top.sv
test/tb_anchor_box_offset_decoder_top.sv
